// File: hw/rtl/cifr_pkg.sv
// shared types and constants for the canopen imu frame receiver
// command codes, status codes, identifier bases and queue entry layout
// no dependencies
`timescale 1ns / 1ps

package cifr_pkg;

  // operation codes on the input stream
  localparam logic [2:0] OP_FRAME  = 3'd0;
  localparam logic [2:0] OP_POLL   = 3'd1;
  localparam logic [2:0] OP_ARM    = 3'd2;
  localparam logic [2:0] OP_CANCEL = 3'd3;
  localparam logic [2:0] OP_TAKE   = 3'd4;

  // frame kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;

  // identifier bases, node number is added
  localparam logic [10:0] BASE_SDO_RESP   = 11'h580;
  localparam logic [10:0] BASE_HEARTBEAT  = 11'h700;
  localparam logic [10:0] BASE_TPDO_ACCEL = 11'h180;
  localparam logic [10:0] BASE_TPDO_GYRO  = 11'h280;

  localparam logic [7:0] SDO_ABORT_CMD = 8'h80;
  localparam logic [3:0] PDO_MIN_LEN   = 4'd6;
  localparam logic [3:0] SDO_MIN_LEN   = 4'd8;

  // reset values of the configuration registers
  localparam logic [6:0] NODE_NUMBER_RESET  = 7'd1;
  localparam logic       LINK_ENABLED_RESET = 1'b1;

  // register indexes
  localparam logic REG_NODE_NUMBER  = 1'b0;
  localparam logic REG_LINK_ENABLED = 1'b1;

  // depth of the queue between classifier and executor
  localparam int QUEUE_DEPTH = 2;

  // classified commands
  localparam logic [3:0] CMD_IGNORE    = 4'd0;
  localparam logic [3:0] CMD_ERR_FRAME = 4'd1;
  localparam logic [3:0] CMD_SDO       = 4'd2;
  localparam logic [3:0] CMD_HEARTBEAT = 4'd3;
  localparam logic [3:0] CMD_ACCEL     = 4'd4;
  localparam logic [3:0] CMD_GYRO      = 4'd5;
  localparam logic [3:0] CMD_POLL      = 4'd6;
  localparam logic [3:0] CMD_ARM       = 4'd7;
  localparam logic [3:0] CMD_CANCEL    = 4'd8;
  localparam logic [3:0] CMD_TAKE      = 4'd9;

  // result status codes
  localparam logic [3:0] ST_IGNORED        = 4'd0;
  localparam logic [3:0] ST_PDO_STORED     = 4'd1;
  localparam logic [3:0] ST_SAMPLE_DONE    = 4'd2;
  localparam logic [3:0] ST_HEARTBEAT      = 4'd3;
  localparam logic [3:0] ST_SDO_OK         = 4'd4;
  localparam logic [3:0] ST_SDO_ABORT      = 4'd5;
  localparam logic [3:0] ST_ERROR_NOTED    = 4'd6;
  localparam logic [3:0] ST_POLL_OK        = 4'd7;
  localparam logic [3:0] ST_POLL_INCOMPLETE = 4'd8;
  localparam logic [3:0] ST_POLL_NO_NEW    = 4'd9;
  localparam logic [3:0] ST_ERROR_TAKEN    = 4'd10;
  localparam logic [3:0] ST_NO_ERROR       = 4'd11;

  typedef struct packed {
    logic [3:0]  code;
    logic [28:0] frame_id;
    logic [63:0] payload;
    logic [31:0] now_us;
    logic [15:0] wait_index;
    logic [7:0]  wait_subindex;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [31:0]        sample_sequence;
    logic [7:0]         node_state;
    logic [31:0]        sample_time_us;
    logic [31:0]        word_out;
    logic [31:0]        error_total;
  } res_t;

endpackage

// File: hw/rtl/cifr_classify.sv
// front end: decodes one input item into a queue command
// classifies frames by identifier against bases plus node number; uses cifr_pkg
`timescale 1ns / 1ps

module cifr_classify (
  input  logic [2:0]         op,
  input  logic [1:0]         frame_kind,
  input  logic [28:0]        frame_id,
  input  logic [3:0]         frame_length,
  input  logic [63:0]        payload,
  input  logic [31:0]        now_us,
  input  logic [15:0]        wait_index,
  input  logic [7:0]         wait_subindex,
  input  logic [6:0]         node_number,
  input  logic               link_enabled,
  output cifr_pkg::cmd_t     cmd
);
  import cifr_pkg::*;

  logic [10:0] node_ext;
  logic [28:0] id_sdo;
  logic [28:0] id_hb;
  logic [28:0] id_accel;
  logic [28:0] id_gyro;
  logic [3:0]  frame_code;

  assign node_ext = {4'b0, node_number};
  assign id_sdo   = {18'b0, BASE_SDO_RESP + node_ext};
  assign id_hb    = {18'b0, BASE_HEARTBEAT + node_ext};
  assign id_accel = {18'b0, BASE_TPDO_ACCEL + node_ext};
  assign id_gyro  = {18'b0, BASE_TPDO_GYRO + node_ext};

  // frame classification, short frames and sdo responses on a disabled link fall to ignore
  always_comb begin
    frame_code = CMD_IGNORE;
    if (frame_kind == KIND_ERROR) begin
      frame_code = CMD_ERR_FRAME;
    end else if (frame_kind == KIND_DATA) begin
      if (frame_id == id_sdo) begin
        if (frame_length >= SDO_MIN_LEN && link_enabled) frame_code = CMD_SDO;
      end else if (frame_id == id_hb) begin
        if (frame_length != 4'd0) frame_code = CMD_HEARTBEAT;
      end else if (frame_id == id_accel) begin
        if (frame_length >= PDO_MIN_LEN) frame_code = CMD_ACCEL;
      end else if (frame_id == id_gyro) begin
        if (frame_length >= PDO_MIN_LEN) frame_code = CMD_GYRO;
      end
    end
  end

  always_comb begin
    cmd.frame_id      = frame_id;
    cmd.payload       = payload;
    cmd.now_us        = now_us;
    cmd.wait_index    = wait_index;
    cmd.wait_subindex = wait_subindex;
    unique case (op)
      OP_FRAME:  cmd.code = frame_code;
      OP_POLL:   cmd.code = CMD_POLL;
      OP_ARM:    cmd.code = CMD_ARM;
      OP_CANCEL: cmd.code = CMD_CANCEL;
      OP_TAKE:   cmd.code = CMD_TAKE;
      default:   cmd.code = CMD_IGNORE;
    endcase
  end

endmodule

// File: hw/rtl/cifr_queue.sv
// short command queue between the classifier and the executor
// circular buffer with a fill count; uses cifr_pkg
`timescale 1ns / 1ps

module cifr_queue #(
  parameter int Depth = cifr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cifr_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output cifr_pkg::cmd_t  head,
  output logic [$clog2(Depth+1)-1:0] level
);
  import cifr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: hw/rtl/cifr_exec.sv
// back end: carries out queued commands against the receiver state
// holds sensor, sdo and error state plus the result register; uses cifr_pkg
`timescale 1ns / 1ps

module cifr_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  cifr_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output cifr_pkg::res_t  res
);
  import cifr_pkg::*;

  logic [15:0] accel_raw [3];
  logic [15:0] gyro_held [3];
  logic [1:0]  ever_valid;
  logic [1:0]  pair_pending;
  logic [31:0] sequence_count;
  logic [7:0]  heartbeat_byte;
  logic [31:0] last_sample_time;
  logic [31:0] last_polled_time;
  logic        sdo_armed;
  logic [15:0] sdo_index_held;
  logic [7:0]  sdo_subindex_held;
  logic        error_pending;
  logic [31:0] error_count;
  logic [28:0] error_id_held;

  logic [1:0]  ever_valid_next;
  logic [1:0]  pair_pending_next;
  logic [31:0] sequence_count_next;
  logic [31:0] last_sample_time_next;
  logic [31:0] last_polled_time_next;
  logic        sdo_armed_next;
  logic        error_pending_next;
  logic [31:0] error_count_next;
  logic        store_accel;
  logic        store_gyro;
  logic        store_hb;
  logic        store_err;
  logic        store_arm;
  res_t        res_next;

  logic [1:0]  pdo_bit;
  logic [1:0]  pend_or;
  logic [31:0] count_inc;
  logic        sdo_match;

  assign cmd_pop = cmd_valid && (!res_valid || res_ready);

  assign pdo_bit   = (cmd.code == CMD_GYRO) ? 2'b10 : 2'b01;
  assign pend_or   = pair_pending | pdo_bit;
  assign count_inc = error_count + 32'd1;
  assign sdo_match = sdo_armed && (cmd.payload[23:8] == sdo_index_held)
                     && (cmd.payload[31:24] == sdo_subindex_held);

  always_comb begin
    ever_valid_next       = ever_valid;
    pair_pending_next     = pair_pending;
    sequence_count_next   = sequence_count;
    last_sample_time_next = last_sample_time;
    last_polled_time_next = last_polled_time;
    sdo_armed_next        = sdo_armed;
    error_pending_next    = error_pending;
    error_count_next      = error_count;
    store_accel           = 1'b0;
    store_gyro            = 1'b0;
    store_hb              = 1'b0;
    store_err             = 1'b0;
    store_arm             = 1'b0;
    res_next              = '0;
    unique case (cmd.code) inside
      CMD_ERR_FRAME: begin
        store_err          = 1'b1;
        error_pending_next = 1'b1;
        error_count_next   = count_inc;
        res_next.status      = ST_ERROR_NOTED;
        res_next.word_out    = {3'b0, cmd.frame_id};
        res_next.error_total = count_inc;
      end
      CMD_SDO: begin
        if (sdo_match) begin
          sdo_armed_next    = 1'b0;
          res_next.status   = (cmd.payload[7:0] == SDO_ABORT_CMD) ? ST_SDO_ABORT : ST_SDO_OK;
          res_next.word_out = cmd.payload[63:32];
        end
      end
      CMD_HEARTBEAT: begin
        store_hb        = 1'b1;
        res_next.status = ST_HEARTBEAT;
      end
      CMD_ACCEL, CMD_GYRO: begin
        store_accel     = (cmd.code == CMD_ACCEL);
        store_gyro      = (cmd.code == CMD_GYRO);
        ever_valid_next = ever_valid | pdo_bit;
        if (pend_or == 2'b11) begin
          last_sample_time_next = cmd.now_us;
          sequence_count_next   = sequence_count + 32'd1;
          pair_pending_next     = 2'b00;
          res_next.status       = ST_SAMPLE_DONE;
        end else begin
          pair_pending_next = pend_or;
          res_next.status   = ST_PDO_STORED;
        end
      end
      CMD_POLL: begin
        if (ever_valid != 2'b11) begin
          res_next.status = ST_POLL_INCOMPLETE;
        end else if (last_sample_time == last_polled_time) begin
          res_next.status = ST_POLL_NO_NEW;
        end else begin
          res_next.status          = ST_POLL_OK;
          res_next.accel_x         = accel_raw[0];
          res_next.accel_y         = accel_raw[1];
          res_next.accel_z         = accel_raw[2];
          res_next.gyro_x          = gyro_held[0];
          res_next.gyro_y          = gyro_held[1];
          res_next.gyro_z          = gyro_held[2];
          res_next.sample_sequence = sequence_count;
          res_next.node_state      = heartbeat_byte;
          res_next.sample_time_us  = last_sample_time;
          last_polled_time_next    = last_sample_time;
        end
      end
      CMD_ARM: begin
        store_arm      = 1'b1;
        sdo_armed_next = 1'b1;
      end
      CMD_CANCEL: begin
        sdo_armed_next = 1'b0;
      end
      CMD_TAKE: begin
        if (error_pending) begin
          res_next.status      = ST_ERROR_TAKEN;
          res_next.word_out    = {3'b0, error_id_held};
          res_next.error_total = error_count;
          error_pending_next   = 1'b0;
          error_count_next     = '0;
        end else begin
          res_next.status = ST_NO_ERROR;
        end
      end
      default: begin
        res_next.status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        accel_raw[i] <= '0;
        gyro_held[i] <= '0;
      end
      ever_valid        <= '0;
      pair_pending      <= '0;
      sequence_count    <= '0;
      heartbeat_byte    <= '0;
      last_sample_time  <= '0;
      last_polled_time  <= '0;
      sdo_armed         <= 1'b0;
      sdo_index_held    <= '0;
      sdo_subindex_held <= '0;
      error_pending     <= 1'b0;
      error_count       <= '0;
      error_id_held     <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (cmd_pop) begin
        ever_valid       <= ever_valid_next;
        pair_pending     <= pair_pending_next;
        sequence_count   <= sequence_count_next;
        last_sample_time <= last_sample_time_next;
        last_polled_time <= last_polled_time_next;
        sdo_armed        <= sdo_armed_next;
        error_pending    <= error_pending_next;
        error_count      <= error_count_next;
        if (store_accel) begin
          accel_raw[0] <= cmd.payload[15:0];
          accel_raw[1] <= cmd.payload[31:16];
          accel_raw[2] <= cmd.payload[47:32];
        end
        if (store_gyro) begin
          gyro_held[0] <= cmd.payload[15:0];
          gyro_held[1] <= cmd.payload[31:16];
          gyro_held[2] <= cmd.payload[47:32];
        end
        if (store_hb)  heartbeat_byte <= cmd.payload[7:0];
        if (store_err) error_id_held  <= cmd.frame_id;
        if (store_arm) begin
          sdo_index_held    <= cmd.wait_index;
          sdo_subindex_held <= cmd.wait_subindex;
        end
      end
      if (cmd_pop)        res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (cmd_pop) res <= res_next;
  end

endmodule

// File: hw/rtl/canopen_imu_frame_receiver_core.sv
// canopen imu frame receiver: items pass a 2-entry queue into the result register;
// throughput one item per cycle while the queue is not full; the executor retires
// one command per cycle unless a result waits, and both sides stall independently
// reset (rst, synchronous): node_number 1, link_enabled 1, all receiver state zero
// depends on cifr_pkg, cifr_classify, cifr_queue, cifr_exec
`timescale 1ns / 1ps

module canopen_imu_frame_receiver_core #(
  parameter int QueueDepth = cifr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  // frame_id[28:0], frame_length[32:29], payload[96:33], now_us[128:97],
  // wait_index[144:129], wait_subindex[152:145], zero fill [159:153]
  input  logic [159:0]  s_tdata,
  // op[2:0], frame_kind[4:3]
  input  logic [4:0]    s_tuser,
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x[63:48],
  // gyro_y[79:64], gyro_z[95:80], sample_sequence[127:96],
  // node_state[135:128], sample_time_us[167:136], word_out[199:168],
  // error_total[231:200]
  output logic [231:0]  m_tdata,
  // status[3:0]
  output logic [3:0]    m_tuser,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import cifr_pkg::*;

  localparam int LevelW = $clog2(QueueDepth + 1);

  logic [6:0]        node_number;
  logic              link_enabled;
  logic              cfg_write;

  cmd_t              front_cmd;
  cmd_t              queue_head;
  logic              queue_full;
  logic              queue_not_empty;
  logic              queue_pop;
  logic              in_transfer;
  logic [LevelW-1:0] queue_level;
  res_t              res;

  // ---------------------------------------------------------------
  // configuration registers, register index is paddr[2]
  // ---------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_number  <= NODE_NUMBER_RESET;
      link_enabled <= LINK_ENABLED_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_NODE_NUMBER) node_number  <= pwdata[6:0];
      else                             link_enabled <= pwdata[0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_NODE_NUMBER) prdata = {25'b0, node_number};
    else                             prdata = {31'b0, link_enabled};
  end

  // ---------------------------------------------------------------
  // front: classify the item and push it straight into the queue
  // ---------------------------------------------------------------
  assign s_tready    = !queue_full;
  assign in_transfer = s_tvalid && s_tready;

  cifr_classify u_classify (
    .op            (s_tuser[2:0]),
    .frame_kind    (s_tuser[4:3]),
    .frame_id      (s_tdata[28:0]),
    .frame_length  (s_tdata[32:29]),
    .payload       (s_tdata[96:33]),
    .now_us        (s_tdata[128:97]),
    .wait_index    (s_tdata[144:129]),
    .wait_subindex (s_tdata[152:145]),
    .node_number   (node_number),
    .link_enabled  (link_enabled),
    .cmd           (front_cmd)
  );

  // queue decouples the front from a stalled result side
  cifr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_transfer),
    .push_cmd  (front_cmd),
    .pop       (queue_pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (queue_head),
    .level     (queue_level)
  );

  // ---------------------------------------------------------------
  // back: execute in order, one per cycle unless stalled, into the result register
  // ---------------------------------------------------------------
  cifr_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_not_empty),
    .cmd       (queue_head),
    .cmd_pop   (queue_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // pack the result, first field lowest
  assign m_tuser = res.status;
  assign m_tdata = {res.error_total, res.word_out, res.sample_time_us, res.node_state,
                    res.sample_sequence, res.gyro_z, res.gyro_y, res.gyro_x,
                    res.accel_z, res.accel_y, res.accel_x};

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_level <= LevelW'(QueueDepth))
    else $error("command queue over its depth");

  // an accepted item is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    in_transfer |=> queue_level != '0)
    else $error("accepted item missing from queue");

  // the executor only pops when a command is there
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    queue_pop |-> queue_not_empty)
    else $error("pop from empty queue");

  // snapshot fields carry data only on a successful poll
  a_snapshot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_POLL_OK) |-> m_tdata[167:0] == '0)
    else $error("snapshot fields set on a non-poll result");

endmodule
